### design/nfa_pkg.sv
// Shared types and constants for the emulated NOR flash array.
// Used by every module of the block except nfa_ram; depends on nothing.
package nfa_pkg;

    // Default geometry
    localparam int DEF_ARRAY_BYTES  = 65536;
    localparam int DEF_SECTOR_BYTES = 4096;

    // Field widths
    localparam int OP_W   = 2;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 17;
    localparam int IDX_W  = 16;
    localparam int DATA_W = 8;

    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

    // Operation codes
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_PROG   = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_RUN   = 4'b0010,
        S_ALIGN = 4'b0100,
        S_ERASE = 4'b1000
    } t_state;

    // Response of the sector alignment unit
    typedef struct packed {
        logic done;
        logic aligned;
    } t_align_rsp;

endpackage

### design/nfa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on a same-address collision. No package dependency.
module nfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/nfa_align.sv
// Sector alignment check: tests whether an in-range address is a multiple of
// the sector size by reciprocal multiplication. Uses nfa_pkg.
module nfa_align #(
    parameter int ARRAY_BYTES  = nfa_pkg::DEF_ARRAY_BYTES,
    parameter int SECTOR_BYTES = nfa_pkg::DEF_SECTOR_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [$clog2(ARRAY_BYTES)-1:0] i_start,
    output nfa_pkg::t_align_rsp            o_rsp
);

    localparam int AW = $clog2(ARRAY_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);
    localparam int K  = AW + SW;
    localparam int MW = 2 * AW + 1;
    localparam int PW = AW + SW + 1;
    // ceil(2^K / SECTOR_BYTES) gives an exact floor quotient for AW-bit inputs
    localparam longint unsigned RECIP =
        ((64'd1 << K) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);
    localparam logic [AW:0] RECIP_C = RECIP[AW:0];

    logic [MW-1:0] w_prod;
    logic [AW-1:0] n_quot, r_quot;
    logic [PW-1:0] w_back;
    logic          n_busy, r_busy;
    logic          n_done, r_done;
    logic          n_aligned, r_aligned;

    always_comb begin
        w_prod    = MW'(i_start) * MW'(RECIP_C);
        n_quot    = AW'(w_prod >> K);
        w_back    = PW'(r_quot) * PW'(SECTOR_BYTES);
        n_busy    = i_go;
        n_done    = r_busy;
        n_aligned = (w_back == PW'(i_start));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot    <= n_quot;
        r_aligned <= n_aligned;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.aligned = r_aligned;

endmodule

### design/nor_flash_array_model_unit.sv
// Emulated NOR flash byte array held in one synchronous RAM. After reset the
// block sweeps 0xFF through every cell with ready low. Reads and programs
// (read, AND, write back) flow at one item per cycle while the output is not
// stalled and no erase is in flight: a result passes the access stage and the
// output register, and back-to-back accesses to the same cell are forwarded
// around the RAM. A sector erase holds the input through a launch step, the
// alignment check and a sweep over its bytes (up to SECTOR_BYTES), bound by the
// single RAM write port. Uses nfa_pkg, nfa_ram, nfa_align.
module nor_flash_array_model_unit #(
    parameter int ARRAY_BYTES  = nfa_pkg::DEF_ARRAY_BYTES,
    parameter int SECTOR_BYTES = nfa_pkg::DEF_SECTOR_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [nfa_pkg::OP_W-1:0]   i_op,
    input  logic [nfa_pkg::ADDR_W-1:0] i_start_address,
    input  logic [nfa_pkg::LEN_W-1:0]  i_transfer_length,
    input  logic [nfa_pkg::IDX_W-1:0]  i_byte_index,
    input  logic [nfa_pkg::DATA_W-1:0] i_write_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [nfa_pkg::DATA_W-1:0] o_read_data,
    output logic                       o_status
);

    localparam int AW = $clog2(ARRAY_BYTES);
    localparam int CW = $clog2(SECTOR_BYTES);
    localparam int DW = nfa_pkg::DATA_W;

    nfa_pkg::t_state     r_state, n_state;
    nfa_pkg::t_align_rsp w_align_rsp;

    // decode of the incoming item
    logic [nfa_pkg::ADDR_W:0]   w_end;
    logic [nfa_pkg::ADDR_W-1:0] w_byte_addr;
    logic                       w_in_ok;
    logic [AW-1:0]              w_in_addr;
    logic                       w_in_acc;

    // access stage
    logic                       r_s1_valid, n_s1_valid;
    logic                       r_s1_pend, n_s1_pend;
    logic                       r_s1_ok, n_s1_ok;
    logic [nfa_pkg::OP_W-1:0]   r_s1_op, n_s1_op;
    logic [AW-1:0]              r_s1_addr, n_s1_addr;
    logic [DW-1:0]              r_s1_wdata, n_s1_wdata;
    logic                       w_s1_adv;
    logic [DW-1:0]              w_ram_rdata;
    logic [DW-1:0]              w_cell;
    logic                       w_prog_we;

    // forwarding of the last program write
    logic                       r_fwd_valid, n_fwd_valid;
    logic [AW-1:0]              r_fwd_addr, n_fwd_addr;
    logic [DW-1:0]              r_fwd_data, n_fwd_data;

    // clear and erase sweep
    logic [AW-1:0]              r_sweep_addr, n_sweep_addr;
    logic [CW-1:0]              r_ers_cnt, n_ers_cnt;
    logic                       w_sweep;
    logic                       w_addr_last;
    logic                       w_align_go;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic [DW-1:0]              r_out_rdata, n_out_rdata;
    logic                       r_out_status, n_out_status;

    // RAM ports
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [DW-1:0]              w_wdata;

    always_comb begin
        w_end       = (nfa_pkg::ADDR_W+1)'(i_start_address)
                    + (nfa_pkg::ADDR_W+1)'(i_transfer_length);
        w_byte_addr = i_start_address + nfa_pkg::ADDR_W'(i_byte_index);
        unique case (i_op)
            nfa_pkg::OP_READ, nfa_pkg::OP_PROG: begin
                w_in_ok   = (nfa_pkg::LEN_W'(i_byte_index) < i_transfer_length)
                         && (w_end <= (nfa_pkg::ADDR_W+1)'(ARRAY_BYTES));
                w_in_addr = AW'(w_byte_addr);
            end
            nfa_pkg::OP_ERASE: begin
                w_in_ok   = i_start_address < nfa_pkg::ADDR_W'(ARRAY_BYTES);
                w_in_addr = AW'(i_start_address);
            end
            default: begin
                w_in_ok   = 1'b0;
                w_in_addr = AW'(i_start_address);
            end
        endcase
    end

    always_comb begin
        w_s1_adv   = r_s1_valid && !r_s1_pend && (r_state == nfa_pkg::S_RUN)
                  && (!r_out_valid || i_out_ready);
        o_in_ready = (r_state == nfa_pkg::S_RUN) && (!r_s1_valid || w_s1_adv);
        w_in_acc   = i_in_valid && o_in_ready;
        w_align_go = (r_state == nfa_pkg::S_RUN) && r_s1_valid && r_s1_pend;

        // take the cell from the last write when the RAM read raced it
        w_cell     = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data
                                                                : w_ram_rdata;
        w_prog_we  = w_s1_adv && r_s1_ok && (r_s1_op == nfa_pkg::OP_PROG);

        w_sweep     = (r_state == nfa_pkg::S_CLEAR) || (r_state == nfa_pkg::S_ERASE);
        w_addr_last = (r_sweep_addr == AW'(ARRAY_BYTES - 1));
        w_we        = w_sweep || w_prog_we;
        w_waddr     = w_sweep ? r_sweep_addr : r_s1_addr;
        w_wdata     = w_sweep ? nfa_pkg::ERASED_BYTE : (w_cell & r_s1_wdata);
    end

    always_comb begin
        n_state      = r_state;
        n_s1_valid   = r_s1_valid;
        n_s1_pend    = r_s1_pend;
        n_s1_ok      = r_s1_ok;
        n_s1_op      = r_s1_op;
        n_s1_addr    = r_s1_addr;
        n_s1_wdata   = r_s1_wdata;
        n_sweep_addr = r_sweep_addr;
        n_ers_cnt    = r_ers_cnt;

        if (w_in_acc) begin
            n_s1_valid = 1'b1;
            n_s1_op    = i_op;
            n_s1_ok    = w_in_ok;
            n_s1_pend  = w_in_ok && (i_op == nfa_pkg::OP_ERASE);
            n_s1_addr  = w_in_addr;
            n_s1_wdata = i_write_data;
        end else if (w_s1_adv) begin
            n_s1_valid = 1'b0;
        end

        unique case (r_state)
            nfa_pkg::S_CLEAR: begin
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (w_addr_last) begin
                    n_state = nfa_pkg::S_RUN;
                end
            end
            nfa_pkg::S_RUN: begin
                if (w_align_go) begin
                    n_state = nfa_pkg::S_ALIGN;
                end
            end
            nfa_pkg::S_ALIGN: begin
                if (w_align_rsp.done) begin
                    if (w_align_rsp.aligned) begin
                        n_sweep_addr = r_s1_addr;
                        n_ers_cnt    = '0;
                        n_state      = nfa_pkg::S_ERASE;
                    end else begin
                        // refuse the misaligned erase
                        n_s1_ok   = 1'b0;
                        n_s1_pend = 1'b0;
                        n_state   = nfa_pkg::S_RUN;
                    end
                end
            end
            nfa_pkg::S_ERASE: begin
                n_sweep_addr = r_sweep_addr + AW'(1);
                n_ers_cnt    = r_ers_cnt + CW'(1);
                // stop at the sector end or at the top of the array
                if (w_addr_last || (r_ers_cnt == CW'(SECTOR_BYTES - 1))) begin
                    n_s1_pend = 1'b0;
                    n_state   = nfa_pkg::S_RUN;
                end
            end
            default: begin
                n_state = nfa_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_fwd_valid = r_fwd_valid;
        n_fwd_addr  = r_fwd_addr;
        n_fwd_data  = r_fwd_data;
        if (w_sweep) begin
            n_fwd_valid = 1'b0;
        end else if (w_s1_adv) begin
            n_fwd_valid = w_prog_we;
        end
        if (w_prog_we) begin
            n_fwd_addr = r_s1_addr;
            n_fwd_data = w_wdata;
        end

        n_out_valid  = r_out_valid;
        n_out_rdata  = r_out_rdata;
        n_out_status = r_out_status;
        if (w_s1_adv) begin
            n_out_valid  = 1'b1;
            n_out_rdata  = (r_s1_ok && (r_s1_op == nfa_pkg::OP_READ)) ? w_cell : '0;
            n_out_status = !r_s1_ok;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nfa_pkg::S_CLEAR;
            r_s1_valid   <= 1'b0;
            r_s1_pend    <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sweep_addr <= '0;
        end else begin
            r_state      <= n_state;
            r_s1_valid   <= n_s1_valid;
            r_s1_pend    <= n_s1_pend;
            r_fwd_valid  <= n_fwd_valid;
            r_out_valid  <= n_out_valid;
            r_sweep_addr <= n_sweep_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ok      <= n_s1_ok;
        r_s1_op      <= n_s1_op;
        r_s1_addr    <= n_s1_addr;
        r_s1_wdata   <= n_s1_wdata;
        r_ers_cnt    <= n_ers_cnt;
        r_fwd_addr   <= n_fwd_addr;
        r_fwd_data   <= n_fwd_data;
        r_out_rdata  <= n_out_rdata;
        r_out_status <= n_out_status;
    end

    nfa_ram #(
        .WIDTH (DW),
        .DEPTH (ARRAY_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_in_addr),
        .o_rdata (w_ram_rdata)
    );

    nfa_align #(
        .ARRAY_BYTES  (ARRAY_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_align_go),
        .i_start (r_s1_addr),
        .o_rsp   (w_align_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_rdata;
    assign o_status    = r_out_status;

endmodule

### design/nfa_chk.sv
// Port-level checker for the NOR flash array block, bound to the top level.
// Uses nfa_pkg for port widths.
module nfa_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [nfa_pkg::OP_W-1:0]   i_op,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [nfa_pkg::DATA_W-1:0] o_read_data,
    input logic                       o_status
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_status))
        else $error("result changed while stalled");

    // a refused item never returns data
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_read_data == '0)
        else $error("refused item returned nonzero data");

    // the array is being cleared right after reset: nothing is taken or shown
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("block active during post-reset clear");

    // an unused opcode is taken only as a refusal, never gets stuck in flight
    a_ready_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_op == nfa_pkg::OP_UNUSED
            |=> o_in_ready || o_out_valid)
        else $error("unused opcode stalled the block");

endmodule

bind nor_flash_array_model_unit nfa_chk u_nfa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_read_data (o_read_data),
    .o_status    (o_status)
);

### verif/tb_nor_flash_array_model_unit.sv
// Testbench for nor_flash_array_model_unit: read, program and sector erase transfers
// checked against a shadow copy of the flash cells kept in a small scoreboard class.
// Depends on nfa_pkg and the block's RTL; reads no files.
module tb_nor_flash_array_model_unit;
    import nfa_pkg::*;

    localparam int ARRAY_BYTES  = DEF_ARRAY_BYTES;
    localparam int SECTOR_BYTES = DEF_SECTOR_BYTES;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;
    localparam int TOTAL_ITEMS  = 1375;
    // The clearing sweep after reset and a full sector erase both run long without
    // any transfer; the limit sits well above both.
    localparam int IDLE_LIMIT   = 250000;
    localparam int TAIL_CYCLES  = 16;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              status;
    } flash_resp_t;

    class flash_shadow;
        logic [DATA_W-1:0] cells [ARRAY_BYTES];
        flash_resp_t       pending_resp [$];
        int unsigned       mismatches;
        int unsigned       n_read, n_prog, n_erase, n_refused, n_checked;

        function new();
            foreach (cells[i]) cells[i] = ERASED_BYTE;
            mismatches = 0;
            n_read     = 0;
            n_prog     = 0;
            n_erase    = 0;
            n_refused  = 0;
            n_checked  = 0;
        endfunction

        // Apply one accepted request to the shadow cells and queue its response.
        function void accept_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] start,
                                     logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx,
                                     logic [DATA_W-1:0] data);
            flash_resp_t resp;
            u64_t        s64;
            u64_t        a;
            s64            = start;
            resp.read_data = '0;
            resp.status    = ST_REFUSED;
            if (op == OP_READ || op == OP_PROG) begin
                // 64-bit sum: a start near the top of the address space must not wrap
                if (idx < len && s64 + len <= ARRAY_BYTES) begin
                    a = s64 + idx;
                    if (op == OP_READ) begin
                        resp.read_data = cells[a];
                        n_read++;
                    end else begin
                        cells[a] = cells[a] & data;
                        n_prog++;
                    end
                    resp.status = ST_OK;
                end
            end else if (op == OP_ERASE) begin
                if (s64 % SECTOR_BYTES == 0 && s64 < ARRAY_BYTES) begin
                    for (a = s64; a < s64 + SECTOR_BYTES; a++) begin
                        if (a >= ARRAY_BYTES) break;
                        cells[a] = ERASED_BYTE;
                    end
                    resp.status = ST_OK;
                    n_erase++;
                end
            end
            if (resp.status == ST_REFUSED) n_refused++;
            pending_resp.push_back(resp);
        endfunction

        function void check_response(logic [DATA_W-1:0] rd, logic st);
            flash_resp_t want;
            if (pending_resp.size() == 0) begin
                $display("%0t: response with none expected, read_data %02h status %0b",
                         $time, rd, st);
                mismatches++;
                return;
            end
            want = pending_resp.pop_front();
            n_checked++;
            if (rd !== want.read_data) begin
                $display("%0t: read_data expected %02h, actual %02h",
                         $time, want.read_data, rd);
                mismatches++;
            end
            if (st !== want.status) begin
                $display("%0t: status expected %0b, actual %0b", $time, want.status, st);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_in_valid        = 1'b0;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_op              = OP_READ;
    logic [ADDR_W-1:0] i_start_address   = '0;
    logic [LEN_W-1:0]  i_transfer_length = '0;
    logic [IDX_W-1:0]  i_byte_index      = '0;
    logic [DATA_W-1:0] i_write_data      = '0;
    logic              o_out_valid;
    logic              i_out_ready       = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic              o_status;

    flash_shadow shadow;
    int unsigned items_sent   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned ready_hold   = 0;
    bit          in_steady    = 1'b0;
    int unsigned next_segment = 0;
    int unsigned next_pause   = 450;
    int unsigned roll;
    int unsigned burst_cell;

    nor_flash_array_model_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_start_address   (i_start_address),
        .i_transfer_length (i_transfer_length),
        .i_byte_index      (i_byte_index),
        .i_write_data      (i_write_data),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_read_data       (o_read_data),
        .o_status          (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, mostly short, with occasional long open stretches.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < 65) begin
            i_out_ready <= 1'b1;
            ready_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                       : $urandom_range(0, 6);
        end else begin
            i_out_ready <= 1'b0;
            ready_hold  <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(0, 3);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_response(o_read_data, o_status);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (in_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Cells clustered in a few windows so reads land on programmed and erased bytes.
    function automatic int unsigned pick_cell();
        case ($urandom_range(0, 4))
            0, 1:    return $urandom_range(0, 31);
            2:       return SECTOR_BYTES + $urandom_range(0, 31);
            3:       return ARRAY_BYTES - 1 - $urandom_range(0, 31);
            default: return $urandom_range(0, ARRAY_BYTES - 1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        // OR two draws half the time so cells keep some ones between erases
        if ($urandom_range(0, 1) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, 255) | $urandom_range(0, 255);
    endfunction

    function automatic logic [OP_W-1:0] pick_access_op();
        return ($urandom_range(0, 1) == 0) ? OP_READ : OP_PROG;
    endfunction

    // Hold valid until the transfer, then note it; a zero gap keeps valid high.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] start,
                             input logic [LEN_W-1:0] len, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data, input int unsigned gap);
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_start_address   <= start;
        i_transfer_length <= len;
        i_byte_index      <= idx;
        i_write_data      <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shadow.accept_request(op, start, len, idx, data);
        items_sent++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (shadow.pending_resp.size() != 0) @(posedge i_clk);
    endtask

    // Well-formed access to one cell, wrapped in a random in-bounds transfer.
    task automatic send_cell_access(input logic [OP_W-1:0] op, input int unsigned target,
                                    input int unsigned gap);
        int unsigned idx, start, len, room;
        idx   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, target)
                                            : $urandom_range(0, (target < 16) ? target : 16);
        start = target - idx;
        room  = ARRAY_BYTES - 1 - target;
        len   = idx + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, room)
                                                       : $urandom_range(0, (room < 16) ? room : 16));
        send_item(op, start, len, idx, pick_data(), gap);
    endtask

    task automatic send_sector_erase(input int unsigned gap);
        int unsigned sector;
        case ($urandom_range(0, 3))
            0:       sector = 0;
            1:       sector = 1;
            2:       sector = ARRAY_BYTES / SECTOR_BYTES - 1;
            default: sector = $urandom_range(0, ARRAY_BYTES / SECTOR_BYTES - 1);
        endcase
        send_item(OP_ERASE, sector * SECTOR_BYTES, $urandom_range(0, 17'h1_FFFF),
                  $urandom_range(0, 16'hFFFF), $urandom_range(0, 255), gap);
    endtask

    // Malformed requests and raw noise; most are refused.
    task automatic send_malformed(input int unsigned gap);
        int unsigned start, len;
        case ($urandom_range(0, 5))
            0: begin
                // runs at least one byte past the end
                start = $urandom_range(1, ARRAY_BYTES - 1);
                len   = ARRAY_BYTES - start + 1 + $urandom_range(0, start - 1);
                if (len > ARRAY_BYTES) len = ARRAY_BYTES;
                send_item(pick_access_op(), start, len, $urandom_range(0, len - 1),
                          pick_data(), gap);
            end
            1: begin
                len = $urandom_range(0, 100);
                send_item(pick_access_op(), $urandom_range(0, 1000), len,
                          len + $urandom_range(0, 100), pick_data(), gap);
            end
            2: send_item(OP_ERASE, $urandom_range(0, ARRAY_BYTES / SECTOR_BYTES - 1) * SECTOR_BYTES
                         + $urandom_range(1, SECTOR_BYTES - 1), $urandom_range(0, 17'h1_FFFF),
                         $urandom_range(0, 16'hFFFF), pick_data(), gap);
            3: send_item(OP_ERASE, $urandom_range(ARRAY_BYTES / SECTOR_BYTES,
                                                  32'hFFFF_FFFF / SECTOR_BYTES) * SECTOR_BYTES,
                         $urandom_range(0, 17'h1_FFFF), $urandom_range(0, 16'hFFFF),
                         pick_data(), gap);
            4: send_item(OP_UNUSED, $urandom_range(0, 31), $urandom_range(1, 64),
                         0, pick_data(), gap);
            default: send_item($urandom_range(0, 3), $urandom, $urandom_range(0, 17'h1_FFFF),
                               $urandom_range(0, 16'hFFFF), $urandom_range(0, 255), gap);
        endcase
    endtask

    initial begin
        shadow = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: erased reads, AND behavior, back-to-back hits, bounds and erase corners.
        send_item(OP_READ, 0, 1, 0, 8'h00, 0);
        send_item(OP_PROG, 0, 1, 0, 8'hA5, 0);
        send_item(OP_READ, 0, 1, 0, 8'hFF, 0);
        send_item(OP_PROG, 0, 4, 0, 8'h0F, 0);
        send_item(OP_PROG, 0, 4, 0, 8'hFF, 0);
        send_item(OP_READ, 0, 4, 0, 8'h00, 1);
        send_item(OP_PROG, 0, ARRAY_BYTES, ARRAY_BYTES - 1, 8'h00, 0);
        send_item(OP_READ, ARRAY_BYTES - 1, 1, 0, 8'h00, 0);
        send_item(OP_READ, ARRAY_BYTES - 1, 2, 0, 8'h00, 0);
        send_item(OP_PROG, ARRAY_BYTES - 2, 3, 1, 8'h00, 0);
        send_item(OP_READ, ARRAY_BYTES - 1, 1, 0, 8'h00, 0);
        send_item(OP_READ, 0, 0, 0, 8'h00, 0);
        send_item(OP_READ, 16, 5, 5, 8'h00, 0);
        send_item(OP_READ, 32'hFFFF_FFFF, 17'h1_FFFF, 16'hFFFF, 8'hFF, 0);
        send_item(OP_READ, 0, 17'h1_FFFF, 0, 8'h00, 0);
        send_item(OP_UNUSED, 0, 1, 0, 8'h00, 0);
        send_item(OP_ERASE, SECTOR_BYTES / 2, 1, 0, 8'h00, 0);
        send_item(OP_ERASE, ARRAY_BYTES, 1, 0, 8'h00, 0);
        send_item(OP_ERASE, 32'hFFFF_FFFF - SECTOR_BYTES + 1, 1, 0, 8'h00, 0);
        send_item(OP_ERASE, ARRAY_BYTES - SECTOR_BYTES, 17'h1_FFFF, 16'hFFFF, 8'h00, 0);
        send_item(OP_READ, ARRAY_BYTES - 1, 1, 0, 8'h00, 0);
        send_item(OP_ERASE, 0, 0, 0, 8'hFF, 0);
        send_item(OP_READ, 0, 1, 0, 8'h00, 0);
        send_item(OP_PROG, 1, 1, 0, 8'h3C, 2);
        send_item(OP_READ, 0, 2, 1, 8'h00, 0);
        wait_drained();

        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= next_segment) begin
                in_steady    = ($urandom_range(0, 3) == 0);
                next_segment = items_sent + 100;
            end
            if (items_sent >= next_pause) begin
                wait_drained();
                next_pause = items_sent + 450;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_sector_erase(pick_gap());
            end else if (roll < 13) begin
                send_malformed(pick_gap());
            end else if (roll < 28) begin
                // same cell back to back to stress forwarding around the RAM
                burst_cell = pick_cell();
                repeat ($urandom_range(1, 3))
                    send_cell_access(pick_access_op(), burst_cell, 0);
                send_cell_access(pick_access_op(), burst_cell, pick_gap());
            end else begin
                send_cell_access(pick_access_op(), pick_cell(), pick_gap());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d responses: %0d reads, %0d programs, %0d sector erases, %0d refused",
                 shadow.n_checked, shadow.n_read, shadow.n_prog, shadow.n_erase,
                 shadow.n_refused);
        if (shadow.mismatches == 0 && shadow.pending_resp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d responses missing", shadow.mismatches,
                     shadow.pending_resp.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
design/nfa_pkg.sv
design/nfa_ram.sv
design/nfa_align.sv
design/nor_flash_array_model_unit.sv
design/nfa_chk.sv
verif/tb_nor_flash_array_model_unit.sv
